[design/bps_pkg.sv]
// Shared constants of the bilinear pixel sampler.
// Field widths, command codes and register indexes used by the interfaces and the RTL.
// No dependencies.
package bps_pkg;

  // Fixed widths of the transaction fields.
  localparam int CMD_W     = 1;
  localparam int WCOORD_W  = 9;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 20;
  localparam int OUT_W     = 16;
  localparam int OUT_FRAC  = 8;

  // Configuration register width, index width and a width that holds any size limit.
  localparam int DIM_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_EXT_W  = 13;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Neighbor order inside the datapath: (x,y), (x+1,y), (x,y+1), (x+1,y+1).
  localparam int NUM_TAPS = 4;

endpackage

[design/bps_in_if.sv]
// Input channel of the bilinear pixel sampler: valid/ready plus one command.
// Depends on bps_pkg for the field widths.
interface bps_in_if;
  import bps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [WCOORD_W-1:0]        write_col;
  logic [WCOORD_W-1:0]        write_row;
  logic [PIX_W-1:0]           pixel_value;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;

  modport source (
    output valid, cmd, write_col, write_row, pixel_value, coord_x, coord_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, write_col, write_row, pixel_value, coord_x, coord_y,
    output ready
  );

endinterface

[design/bps_out_if.sv]
// Result channel of the bilinear pixel sampler: valid/ready plus one sample.
// Depends on bps_pkg for the field width.
interface bps_out_if;
  import bps_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] sample_value;

  modport source (
    output valid, sample_value,
    input  ready
  );

  modport sink (
    input  valid, sample_value,
    output ready
  );

endinterface

[design/bps_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/bilinear_pixel_sampler.sv]
// Bilinear pixel sampler: image store in four parity banks and a four-stage sampling pipeline.
// Depends on bps_pkg, bps_in_if, bps_out_if and bps_ram.
//
//   channel   direction  handshake                    payload
//   in_ch     in         valid/ready                  cmd, write_col, write_row, pixel_value,
//                                                     coord_x, coord_y
//   out_ch    out        valid/ready                  sample_value
//   cfg_*     in         cfg_we, no wait              cfg_index, cfg_wdata
//
// One transaction is taken per cycle while in_ch.ready is high. A sample passes through
// clamp, bank read with weight products, pixel products, then sum and rounding into the
// output register. A write retires in the second stage when its bank is written.
// Reset clears the valid bits and sets both sizes to the lesser of 512 and the limit;
// the pixel banks are not cleared. On a stall a stage holds while the next one is full and stalled.
module bilinear_pixel_sampler #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bps_in_if.sink                        in_ch,
  bps_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bps_pkg::DIM_W-1:0]     cfg_wdata
);
  import bps_pkg::*;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int HCOL_W   = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int HROW_W   = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int BANK_AW  = HCOL_W + HROW_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CMP_W    = (DIM_W + FRAC_BITS + 1 > COORD_W) ? DIM_W + FRAC_BITS + 1
                                                              : COORD_W;
  localparam int W1_W     = FRAC_BITS + 1;
  localparam int WT_W     = 2 * FRAC_BITS + 1;
  localparam int PROD_W   = WT_W + PIX_W;
  localparam int SH       = 2 * FRAC_BITS - OUT_FRAC;
  localparam int RND      = (1 << SH) >> 1;
  localparam int ONE      = 1 << FRAC_BITS;
  localparam int RST_WIDTH  = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
  localparam int RST_HEIGHT = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

  // Clamp one axis: negative goes to zero, at or past size-1 goes to size-2 exactly.
  function automatic logic [CMP_W-1:0] clamp_axis(input logic signed [COORD_W-1:0] c,
                                                  input logic [DIM_W-1:0] n);
    logic signed [CMP_W-1:0] cs;
    logic signed [CMP_W-1:0] lim;
    logic [CMP_W-1:0]        res;
    cs  = CMP_W'(c);
    lim = signed'(CMP_W'(n - DIM_W'(1)) << FRAC_BITS);
    if (cs < 0) begin
      res = '0;
    end else if (cs >= lim) begin
      res = CMP_W'(n - DIM_W'(2)) << FRAC_BITS;
    end else begin
      res = unsigned'(cs);
    end
    return res;
  endfunction

  // Saturate a written size to [2, limit].
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_EXT_W-1:0] ve;
    logic [DIM_W-1:0]     res;
    ve = DIM_EXT_W'(v);
    if (ve < DIM_EXT_W'(2)) begin
      res = DIM_W'(2);
    end else if (ve > DIM_EXT_W'(hi)) begin
      res = DIM_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [DIM_W-1:0] img_w_r, img_w_nxt;
  logic [DIM_W-1:0] img_h_r, img_h_nxt;

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
      img_w_nxt = sat_dim(cfg_wdata, MAX_WIDTH);
    end
    if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
      img_h_nxt = sat_dim(cfg_wdata, MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= DIM_W'(RST_WIDTH);
      img_h_r <= DIM_W'(RST_HEIGHT);
    end else begin
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_wr_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_go;
  logic in_acc;

  assign rdy4   = !out_v_r || out_ch.ready;
  assign rdy3   = !s3_v_r || rdy4;
  assign rdy2   = !s2_v_r || rdy3;
  // A write retires in stage 1 and never waits on the stages behind it.
  assign rdy1   = !s1_v_r || s1_wr_r || rdy2;
  assign s1_go  = s1_v_r && !s1_wr_r && rdy2;
  assign in_acc = in_ch.valid && rdy1;
  assign in_ch.ready = rdy1;

  // ---------------------------------------------------------------- stage 0: clamp
  logic [CMP_W-1:0]     cx, cy;
  logic [COL_W-1:0]     ix_nxt;
  logic [ROW_W-1:0]     iy_nxt;
  logic [FRAC_BITS-1:0] fx_nxt, fy_nxt;
  logic [DIM_EXT_W-1:0] wcol_ext, wrow_ext;
  logic                 wok_nxt;

  always_comb begin
    cx       = clamp_axis(in_ch.coord_x, img_w_r);
    cy       = clamp_axis(in_ch.coord_y, img_h_r);
    ix_nxt   = COL_W'(cx >> FRAC_BITS);
    iy_nxt   = ROW_W'(cy >> FRAC_BITS);
    fx_nxt   = cx[FRAC_BITS-1:0];
    fy_nxt   = cy[FRAC_BITS-1:0];
    wcol_ext = DIM_EXT_W'(in_ch.write_col);
    wrow_ext = DIM_EXT_W'(in_ch.write_row);
    wok_nxt  = (wcol_ext < DIM_EXT_W'(MAX_WIDTH)) && (wrow_ext < DIM_EXT_W'(MAX_HEIGHT));
  end

  logic [COL_W-1:0]     s1_ix_r;
  logic [ROW_W-1:0]     s1_iy_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fy_r;
  logic                 s1_wok_r;
  logic [HCOL_W-1:0]    s1_wch_r;
  logic [HROW_W-1:0]    s1_wrh_r;
  logic                 s1_wcp_r, s1_wrp_r;
  logic [PIX_W-1:0]     s1_wpix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_wr_r   <= (in_ch.cmd == CMD_WRITE);
      s1_ix_r   <= ix_nxt;
      s1_iy_r   <= iy_nxt;
      s1_fx_r   <= fx_nxt;
      s1_fy_r   <= fy_nxt;
      s1_wok_r  <= wok_nxt;
      s1_wch_r  <= HCOL_W'(wcol_ext >> 1);
      s1_wrh_r  <= HROW_W'(wrow_ext >> 1);
      s1_wcp_r  <= wcol_ext[0];
      s1_wrp_r  <= wrow_ext[0];
      s1_wpix_r <= in_ch.pixel_value;
    end
  end

  // ---------------------------------------------------------------- stage 1: banks, weights
  // The even bank of an axis holds ix or ix+1, whichever is even; the odd bank the other.
  logic [HCOL_W-1:0] chalf_e, chalf_o;
  logic [HROW_W-1:0] rhalf_e, rhalf_o;

  assign chalf_e = HCOL_W'((s1_ix_r >> 1) + COL_W'(s1_ix_r[0]));
  assign chalf_o = HCOL_W'(s1_ix_r >> 1);
  assign rhalf_e = HROW_W'((s1_iy_r >> 1) + ROW_W'(s1_iy_r[0]));
  assign rhalf_o = HROW_W'(s1_iy_r >> 1);

  logic [NUM_TAPS-1:0] bank_we;
  logic [PIX_W-1:0]    bank_rdata [NUM_TAPS];

  for (genvar b = 0; b < NUM_TAPS; b++) begin : g_bank
    localparam logic CP = logic'(b % 2);
    localparam logic RP = logic'(b / 2);
    logic [BANK_AW-1:0] raddr;
    logic [BANK_AW-1:0] waddr;

    assign raddr      = {(RP ? rhalf_o : rhalf_e), (CP ? chalf_o : chalf_e)};
    assign waddr      = {s1_wrh_r, s1_wch_r};
    assign bank_we[b] = s1_v_r && s1_wr_r && s1_wok_r && (s1_wrp_r == RP) && (s1_wcp_r == CP);

    bps_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (s1_wpix_r),
      .re    (s1_go),
      .raddr (raddr),
      .rdata (bank_rdata[b])
    );
  end

  // Corner weights in tap order.
  logic [W1_W-1:0] ofx, ofy, efx, efy;
  logic [WT_W-1:0] w_nxt [NUM_TAPS];

  always_comb begin
    efx      = W1_W'(s1_fx_r);
    efy      = W1_W'(s1_fy_r);
    ofx      = W1_W'(ONE) - efx;
    ofy      = W1_W'(ONE) - efy;
    w_nxt[0] = WT_W'(ofx) * WT_W'(ofy);
    w_nxt[1] = WT_W'(efx) * WT_W'(ofy);
    w_nxt[2] = WT_W'(ofx) * WT_W'(efy);
    w_nxt[3] = WT_W'(efx) * WT_W'(efy);
  end

  logic [WT_W-1:0] s2_w_r [NUM_TAPS];
  logic            s2_px_r, s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_w_r  <= w_nxt;
      s2_px_r <= s1_ix_r[0];
      s2_py_r <= s1_iy_r[0];
    end
  end

  // ---------------------------------------------------------------- stage 2: pixel products
  // Bank index is {row parity, column parity}; route each bank to its corner.
  logic [PIX_W-1:0]  tap_pix [NUM_TAPS];
  logic [PROD_W-1:0] prod_nxt [NUM_TAPS];

  always_comb begin
    tap_pix[0] = bank_rdata[{s2_py_r, s2_px_r}];
    tap_pix[1] = bank_rdata[{s2_py_r, !s2_px_r}];
    tap_pix[2] = bank_rdata[{!s2_py_r, s2_px_r}];
    tap_pix[3] = bank_rdata[{!s2_py_r, !s2_px_r}];
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod_nxt[k] = PROD_W'(s2_w_r[k]) * PROD_W'(tap_pix[k]);
    end
  end

  logic [PROD_W-1:0] s3_prod_r [NUM_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_prod_r <= prod_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3: sum and round
  logic [PROD_W-1:0] sum;
  logic [OUT_W-1:0]  sample_nxt;

  always_comb begin
    sum        = s3_prod_r[0] + s3_prod_r[1] + s3_prod_r[2] + s3_prod_r[3] + PROD_W'(RND);
    sample_nxt = OUT_W'(sum >> SH);
  end

  logic [OUT_W-1:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy4) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.sample_value = out_sample_r;

`ifndef SYNTHESIS
  // Sizes stay inside [2, limit] whatever is written.
  a_dims_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (DIM_EXT_W'(img_w_r) >= DIM_EXT_W'(2)) && (DIM_EXT_W'(img_w_r) <= DIM_EXT_W'(MAX_WIDTH)) &&
    (DIM_EXT_W'(img_h_r) >= DIM_EXT_W'(2)) && (DIM_EXT_W'(img_h_r) <= DIM_EXT_W'(MAX_HEIGHT)))
    else $error("image size register out of range");

  // A write touches one bank at most, and never in the cycle a sample reads the banks.
  a_bank_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we) && !(s1_go && (bank_we != '0)))
    else $error("bank write conflicts with another access");

  // Stage 3 holds its products while the output register is stalled.
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !rdy4 |=> s3_v_r && $stable(s3_prod_r[0]) && $stable(s3_prod_r[3]))
    else $error("stage 3 lost data during a stall");

  // A new result only appears when stage 3 held a sample.
  a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s3_v_r))
    else $error("result appeared without a sample in stage 3");
`endif

endmodule
